[sv/tmrws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrws_pkg
// shared constants, types and table builder for the ramp and wave setpoint
// ----------------------------------------------------------------------------
package tmrws_pkg;

   localparam int TIME_FRAC_BITS  = 13;
   localparam int SINE_TABLE_BITS = 10;

   localparam int TIME_W  = 16;
   localparam int TQ_W    = 32 - TIME_FRAC_BITS;
   localparam int CMP_W   = (TQ_W > 18) ? TQ_W : 18;
   localparam int TQ5_W   = CMP_W + 3;
   localparam int QTR_LEN = 1 << (SINE_TABLE_BITS - 2);
   localparam int QIDX_W  = SINE_TABLE_BITS - 1;
   localparam int NUM_W   = 48;
   localparam int OUT_W   = 16;
   localparam int NUM_STAGES = 5;

   localparam logic [14:0] CLOSED_RESET = 15'd19000;
   localparam logic [13:0] AMP_RESET    = 14'd5000;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic [31:0] QTR_TURN       = 32'h4000_0000;
   localparam logic [31:0] THREE_QTR_TURN = 32'hC000_0000;

   // register select on paddr[2]
   localparam logic REG_CLOSED = 1'b0;
   localparam logic REG_AMP    = 1'b1;

   // ramp segments
   localparam logic [1:0] RAMP_SQ   = 2'd0;
   localparam logic [1:0] RAMP_LIN  = 2'd1;
   localparam logic [1:0] RAMP_TOP  = 2'd2;
   localparam logic [1:0] RAMP_FULL = 2'd3;

   // envelope segments
   localparam logic [1:0] ENV_RISE = 2'd0;
   localparam logic [1:0] ENV_FLAT = 2'd1;
   localparam logic [1:0] ENV_FALL = 2'd2;
   localparam logic [1:0] ENV_ZERO = 2'd3;

   typedef struct packed {
      logic valid;
      logic load;
      logic ready;
   } cell_ctl_type;

   typedef logic [15:0] qtr_rom_type [QTR_LEN + 1];

   // quarter sine wave, taylor series in q30, rounded to q15
   function automatic qtr_rom_type build_qtr_rom();
      qtr_rom_type rom;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      for (int r = 0; r <= QTR_LEN; r++) begin
         a    = (HALF_PI_Q30 * 64'(r)) >> (SINE_TABLE_BITS - 2);
         a2   = (a * a) >> 30;
         term = a;
         sum  = a;
         for (int n = 1; n <= 7; n++) begin
            term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum + 64'd16384) >> 15;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[r] = v[15:0];
      end
      return rom;
   endfunction

   localparam qtr_rom_type QTR_ROM = build_qtr_rom();

   // phase to nearest table entry, with wraparound
   function automatic logic [SINE_TABLE_BITS-1:0] sine_index(input logic [31:0] phase);
      logic [32:0] sum;
      sum = {1'b0, phase} + (33'd1 << (31 - SINE_TABLE_BITS));
      return sum[31:32-SINE_TABLE_BITS];
   endfunction

   // divide by 2^30 toward zero, then saturate to 16 bits
   function automatic logic signed [OUT_W-1:0] trunc_sat(input logic signed [NUM_W-1:0] num);
      logic signed [NUM_W-1:0] q;
      if (num < 0) begin
         q = (num + $signed(NUM_W'((64'd1 << 30) - 64'd1))) >>> 30;
      end else begin
         q = num >>> 30;
      end
      if (q > $signed(NUM_W'(32767))) begin
         return 16'sh7FFF;
      end else if (q < -$signed(NUM_W'(32768))) begin
         return 16'sh8000;
      end else begin
         return q[OUT_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

[sv/tmrws_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrws_cell
// one link of the pipeline chain: holds a valid bit, loads when it can pass on
// ----------------------------------------------------------------------------
module tmrws_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  up_valid,
   input  wire logic                  dn_ready,
   output tmrws_pkg::cell_ctl_type    ctl
);
   import tmrws_pkg::*;

   logic valid_ff;
   logic valid_in;
   logic ready;

   // free when empty or when the next cell takes our content
   assign ready    = !valid_ff || dn_ready;
   assign valid_in = ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.valid = valid_ff;
   assign ctl.ready = ready;
   assign ctl.load  = ready && up_valid;

endmodule
`default_nettype wire

[sv/tmrws_sine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmrws_sine
// quarter-wave table lookup with symmetry for the other three quarters
// ----------------------------------------------------------------------------
module tmrws_sine (
   input  wire logic [tmrws_pkg::SINE_TABLE_BITS-1:0] idx,
   output logic signed [15:0]                         value
);
   import tmrws_pkg::*;

   logic [1:0]        quad;
   logic [QIDX_W-1:0] r;
   logic [QIDX_W-1:0] addr;
   logic [15:0]       mag;

   assign quad = idx[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
   assign r    = QIDX_W'(idx[SINE_TABLE_BITS-3:0]);

   // odd quarters run the table backward
   assign addr  = quad[0] ? (QIDX_W'(QTR_LEN) - r) : r;
   assign mag   = QTR_ROM[addr];
   assign value = quad[1] ? -$signed(mag) : $signed(mag);

endmodule
`default_nettype wire

[sv/two_motor_ramp_wave_setpoint.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_motor_ramp_wave_setpoint
// opening ramp plus enveloped 4 hz wave, giving two motor setpoints per sample
// ----------------------------------------------------------------------------
// Each request carries a time sample (unsigned, TIME_FRAC_BITS fraction bits)
// and yields exactly one response with two signed 16-bit setpoints:
// closed - ramp*closed -/+ sine*envelope*amplitude, truncated toward zero and
// saturated. The block takes one request per clock while req_stall is low.
// Its response is registered through a chain of five pipeline cells (ramp
// and table index, table lookup, first products, wave product, final sum).
// Each cell holds its content while the next one is full and stalled, so
// requests keep entering as long as there is an empty cell anywhere downstream.
// Registers: closed_position at byte 0, wave_amplitude at byte 4; write them
// only while no request is in flight.
// ----------------------------------------------------------------------------
module two_motor_ramp_wave_setpoint (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tmrws_pkg::TIME_W-1:0]  req_time_sample,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [tmrws_pkg::OUT_W-1:0] rsp_first_motor_setpoint,
   output logic signed [tmrws_pkg::OUT_W-1:0] rsp_second_motor_setpoint,

   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [2:0]                    csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import tmrws_pkg::*;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [14:0] closed_ff;
   logic [13:0] amp_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff <= CLOSED_RESET;
         amp_ff    <= AMP_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_CLOSED: closed_ff <= csr_pwdata[14:0];
            REG_AMP:    amp_ff    <= csr_pwdata[13:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_CLOSED: csr_prdata = 32'(closed_ff);
         REG_AMP:    csr_prdata = 32'(amp_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // chain of control cells
   // ------------------------------------------------------------------
   cell_ctl_type ctl      [NUM_STAGES];
   logic         up_valid [NUM_STAGES];
   logic         dn_ready [NUM_STAGES];

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_chain
      if (i == 0) begin : g_head
         assign up_valid[i] = req_valid;
      end else begin : g_mid
         assign up_valid[i] = ctl[i-1].valid;
      end
      if (i == NUM_STAGES - 1) begin : g_tail
         assign dn_ready[i] = !rsp_stall;
      end else begin : g_next
         assign dn_ready[i] = ctl[i+1].ready;
      end
      tmrws_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (up_valid[i]),
         .dn_ready (dn_ready[i]),
         .ctl      (ctl[i])
      );
   end

   assign req_stall = !ctl[0].ready;
   assign rsp_valid = ctl[NUM_STAGES-1].valid;

   // ------------------------------------------------------------------
   // stage 0: ramp complement and table indexes
   // ------------------------------------------------------------------
   logic [CMP_W-1:0]            tq;
   logic [TQ5_W-1:0]            tq5;
   logic [1:0]                  ramp_seg;
   logic [15:0]                 sq_op;
   logic [31:0]                 sq;
   logic [14:0]                 sq_s;
   logic [14:0]                 lin;
   logic [CMP_W-1:0]            lin_diff;
   logic [31:0]                 env_phase;
   logic [15:0]                 k_in;
   logic [1:0]                  env_mode_in;
   logic [SINE_TABLE_BITS-1:0]  env_idx_in;
   logic [SINE_TABLE_BITS-1:0]  wave_idx_in;

   logic [15:0]                 k_ff;
   logic [1:0]                  env_mode_ff;
   logic [SINE_TABLE_BITS-1:0]  env_idx_ff;
   logic [SINE_TABLE_BITS-1:0]  wave_idx_ff;

   // time as unsigned q16 seconds
   assign tq  = CMP_W'(req_time_sample) << (16 - TIME_FRAC_BITS);
   assign tq5 = TQ5_W'(tq) * TQ5_W'(5);

   always_comb begin
      if (tq < CMP_W'(32768)) begin
         ramp_seg = RAMP_SQ;
      end else if (tq < CMP_W'(98304)) begin
         ramp_seg = RAMP_LIN;
      end else if (tq < CMP_W'(131072)) begin
         ramp_seg = RAMP_TOP;
      end else begin
         ramp_seg = RAMP_FULL;
      end
   end

   // squared term: t itself near the start, (2 - t) near the top
   assign sq_op    = (ramp_seg == RAMP_SQ) ? tq[15:0] : 16'(CMP_W'(131072) - tq);
   assign sq       = sq_op * sq_op;
   assign sq_s     = sq[31:17];
   assign lin_diff = (tq - CMP_W'(32768)) >> 2;
   assign lin      = 15'(lin_diff) + 15'd8192;

   // keep 1 - ramp, which is what the base term needs
   always_comb begin
      case (ramp_seg)
         RAMP_SQ:   k_in = 16'd32768 - 16'(sq_s);
         RAMP_LIN:  k_in = 16'd32768 - 16'(lin);
         RAMP_TOP:  k_in = 16'(sq_s);
         default:   k_in = '0;
      endcase
   end

   always_comb begin
      if (tq5 < TQ5_W'(65536)) begin
         env_mode_in = ENV_RISE;
      end else if (tq < CMP_W'(65536)) begin
         env_mode_in = ENV_FLAT;
      end else if (tq < CMP_W'(98304)) begin
         env_mode_in = ENV_FALL;
      end else begin
         env_mode_in = ENV_ZERO;
      end
   end

   // cosine phases for the rising and falling edges of the envelope
   assign env_phase   = (env_mode_in == ENV_RISE) ? ((32'(tq5) << 15) + QTR_TURN)
                                                  : ((32'(tq) << 16) + THREE_QTR_TURN);
   assign env_idx_in  = sine_index(env_phase);
   assign wave_idx_in = sine_index(32'(tq) << 18);

   always_ff @(posedge clock) begin
      if (ctl[0].load) begin
         k_ff        <= k_in;
         env_mode_ff <= env_mode_in;
         env_idx_ff  <= env_idx_in;
         wave_idx_ff <= wave_idx_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: table lookups and envelope
   // ------------------------------------------------------------------
   logic signed [15:0] cos_val;
   logic signed [15:0] sin_in;
   logic signed [17:0] env_sum;
   logic [15:0]        env_in;

   logic [15:0]        k1_ff;
   logic signed [15:0] sin_ff;
   logic [15:0]        env_ff;

   tmrws_sine u_env_sine (
      .idx   (env_idx_ff),
      .value (cos_val)
   );

   tmrws_sine u_wave_sine (
      .idx   (wave_idx_ff),
      .value (sin_in)
   );

   always_comb begin
      env_sum = '0;
      case (env_mode_ff)
         ENV_RISE: begin
            env_sum = 18'sd32768 - 18'(cos_val);
            env_in  = 16'(env_sum >>> 1);
         end
         ENV_FLAT: env_in = 16'd32768;
         ENV_FALL: begin
            env_sum = 18'sd32768 + 18'(cos_val);
            env_in  = 16'(env_sum >>> 1);
         end
         default:  env_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl[1].load) begin
         k1_ff  <= k_ff;
         sin_ff <= sin_in;
         env_ff <= env_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: closed*(1-ramp) and sine*envelope
   // ------------------------------------------------------------------
   logic [30:0]        ck_in;
   logic signed [32:0] se_full;

   logic [30:0]        ck_ff;
   logic signed [31:0] se_ff;

   assign ck_in   = closed_ff * k1_ff;
   assign se_full = sin_ff * $signed({1'b0, env_ff});

   always_ff @(posedge clock) begin
      if (ctl[2].load) begin
         ck_ff <= ck_in;
         se_ff <= $signed(se_full[31:0]);
      end
   end

   // ------------------------------------------------------------------
   // stage 3: wave times amplitude, base aligned to q30
   // ------------------------------------------------------------------
   logic signed [46:0]      wave_full;
   logic signed [NUM_W-1:0] base_ff;
   logic signed [NUM_W-1:0] wave_ff;

   assign wave_full = se_ff * $signed({1'b0, amp_ff});

   always_ff @(posedge clock) begin
      if (ctl[3].load) begin
         base_ff <= $signed({2'b00, ck_ff, 15'd0});
         wave_ff <= NUM_W'(wave_full);
      end
   end

   // ------------------------------------------------------------------
   // stage 4: sums, truncation toward zero, saturation, output register
   // ------------------------------------------------------------------
   logic signed [OUT_W-1:0] first_ff;
   logic signed [OUT_W-1:0] second_ff;

   always_ff @(posedge clock) begin
      if (ctl[4].load) begin
         first_ff  <= trunc_sat(base_ff - wave_ff);
         second_ff <= trunc_sat(base_ff + wave_ff);
      end
   end

   assign rsp_first_motor_setpoint  = first_ff;
   assign rsp_second_motor_setpoint = second_ff;

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the ramp and wave setpoint generator against its own predictor
// ----------------------------------------------------------------------------
// Time samples go in through the request channel in random bursts. The
// response side stalls on its own pattern. An independent predictor works out
// the two setpoints for every accepted request, using the closed position and
// wave amplitude last written over the register port, or else their reset
// values. Each response is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import tmrws_pkg::*;

   localparam int QLEN = 256;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [15:0] req_time_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_first_motor_setpoint;
   logic signed [15:0] rsp_second_motor_setpoint;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // predictor copy of the registers
   logic [14:0] closed_q;
   logic [13:0] amp_q;
   int quarter_sine [QLEN + 1];

   typedef struct {
      logic signed [15:0] first;
      logic signed [15:0] second;
   } setpoint_pair_type;
   setpoint_pair_type pending_setpoints [$];

   int mismatches;
   int cycles;
   int stall_mode;

   two_motor_ramp_wave_setpoint DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // quarter wave table: taylor series in q30, rounded to q15
   function automatic void fill_quarter_sine();
      logic [63:0] a, a2, term, sum, v;
      for (int r = 0; r <= QLEN; r++) begin
         a = (64'd1686629713 * 64'(r)) >> 8;
         a2 = (a * a) >> 30;
         term = a;
         sum = a;
         for (int n = 1; n <= 7; n++) begin
            term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         v = (sum + 64'd16384) >> 15;
         if (v > 64'd32767) v = 64'd32767;
         quarter_sine[r] = int'(v);
      end
   endfunction

   function automatic int table_sine(logic [31:0] phase);
      logic [33:0] rounded;
      logic [9:0] idx;
      int mag;
      rounded = {2'b0, phase} + 34'(1 << 21);
      idx = rounded[31:22];
      if (idx[8]) mag = quarter_sine[QLEN - int'(idx[7:0])];
      else mag = quarter_sine[idx[7:0]];
      return idx[9] ? -mag : mag;
   endfunction

   function automatic logic signed [15:0] div_sat(longint num);
      longint q;
      q = num / 64'sd1073741824;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic setpoint_pair_type predict_setpoints(logic [15:0] ts);
      longint tq, ramp, env, d, base, wave;
      int c;
      setpoint_pair_type p;
      tq = longint'(ts) << 3;
      if (tq < 32768) ramp = (tq * tq) >> 17;
      else if (tq < 98304) ramp = ((tq - 32768) >> 2) + 8192;
      else if (tq < 131072) begin
         d = 131072 - tq;
         ramp = 32768 - ((d * d) >> 17);
      end else ramp = 32768;
      if (tq * 5 < 65536) begin
         c = table_sine(32'((tq * 5) << 15) + 32'h4000_0000);
         env = (32768 - c) >>> 1;
      end else if (tq < 65536) env = 32768;
      else if (tq < 98304) begin
         c = table_sine(32'(tq << 16) + 32'hC000_0000);
         env = (32768 + c) >>> 1;
      end else env = 0;
      base = longint'(closed_q) * 64'sd1073741824 - ramp * longint'(closed_q) * 32768;
      wave = longint'(table_sine(32'(tq << 18))) * env * longint'(amp_q);
      p.first = div_sat(base - wave);
      p.second = div_sat(base + wave);
      return p;
   endfunction

   // apb write: setup cycle then access cycle
   task automatic write_register(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == 3'd0) closed_q = data[14:0];
      else if (addr == 3'd4) amp_q = data[13:0];
   endtask

   // send one request, with a random gap before it when not in a burst
   int burst_left;
   task automatic send_request(logic [15:0] ts);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_time_sample <= ts;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_setpoints.push_back(predict_setpoints(ts));
      burst_left--;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic test_directed_extremes();
      logic [15:0] pts [] = '{16'd0, 16'd1, 16'd819, 16'd1638, 16'd1639, 16'd2048,
                              16'd4095, 16'd4096, 16'd6144, 16'd8191, 16'd8192,
                              16'd10000, 16'd12287, 16'd12288, 16'd14000, 16'd16383,
                              16'd16384, 16'd20000, 16'd32768, 16'd65535, 16'hAAAA,
                              16'h5555};
      foreach (pts[i]) send_request(pts[i]);
      drain();
   endtask

   task automatic test_random_phase(int n, int span);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) send_request(16'($urandom));
         else send_request(16'($urandom_range(0, span)));
      end
      drain();
   endtask

   task automatic test_register_settings();
      write_register(3'd0, 32'd32767);
      write_register(3'd4, 32'd16383);
      test_random_phase(150, 17000);
      write_register(3'd0, 32'd0);
      write_register(3'd4, 32'd0);
      test_random_phase(60, 17000);
      write_register(3'd0, 32'hFFFF_FFFF);
      write_register(3'd4, 32'd0);
      test_random_phase(60, 17000);
      write_register(3'd0, 32'd0);
      write_register(3'd4, 32'hFFFF_FFFF);
      test_random_phase(60, 17000);
      write_register(3'd0, $urandom);
      write_register(3'd4, $urandom);
      test_random_phase(150, 17000);
   endtask

   // response stall pattern: modes switch at random between none, light and heavy
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
   end

   // response checker
   always @(posedge clock) begin
      setpoint_pair_type exp_sp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_setpoints.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %0d %0d",
               rsp_first_motor_setpoint, rsp_second_motor_setpoint);
         end else begin
            exp_sp = pending_setpoints.pop_front();
            if (exp_sp.first !== rsp_first_motor_setpoint ||
                exp_sp.second !== rsp_second_motor_setpoint) begin
               mismatches++;
               if (mismatches <= 10) $display("setpoint mismatch exp %0d %0d got %0d %0d",
                  exp_sp.first, exp_sp.second, rsp_first_motor_setpoint,
                  rsp_second_motor_setpoint);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_time_sample = '0;
      rsp_stall = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatches = 0;
      cycles = 0;
      stall_mode = 1;
      burst_left = 0;
      closed_q = 15'd19000;
      amp_q = 14'd5000;
      fill_quarter_sine();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_random_phase(150, 17000);
      test_register_settings();
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
